// ===== hdl/jpu_pkg.sv =====
// Shared types, codes and arithmetic helpers for the joystick packet unpacker.
// No dependencies; used by the top level and its checker.
package jpu_pkg;

    localparam int PACKET_BYTES = 25;
    localparam int STORE_DEPTH  = PACKET_BYTES - 1;  // byte 24 is compared, never stored
    localparam int LAST_IDX     = PACKET_BYTES - 1;
    localparam int NUM_AXES     = 4;
    localparam int NUM_BUTTONS  = 5;
    localparam int FIRST_BUTTON = 19;

    localparam int AXIS_W = 16;   // stored raw / bias width
    localparam int OUT_W  = 17;   // corrected axis width
    localparam int DZ_W   = 15;
    localparam int ADDR_W = 24;

    // float exponent limits: shift = EXP_UNITY - exponent
    localparam logic [7:0] EXP_UNITY   = 8'd139;
    localparam logic [7:0] EXP_ZERO_LO = 8'd115;   // shift of 24 or more
    localparam logic [14:0] AXIS_MAX   = 15'h7FFF;

    // input function codes
    localparam logic [1:0] FUNC_BYTE    = 2'd0;
    localparam logic [1:0] FUNC_CAPTURE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_CSUM = 2'd1;
    localparam logic [1:0] ST_ADDR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CHECK_EN  = 2'd0;
    localparam logic [1:0] CFG_MY_ADDR   = 2'd1;
    localparam logic [1:0] CFG_DEAD_ZONE = 2'd2;

    typedef logic signed [AXIS_W-1:0] axis_t;
    typedef logic signed [OUT_W-1:0]  axis_out_t;

    // Little-endian IEEE single to saturated signed fixed point.
    function automatic axis_t float_to_fixed(input logic [31:0] w);
        logic [7:0]  ex;
        logic [23:0] mant;
        logic [4:0]  sh;
        logic [23:0] shifted;
        logic [14:0] mag;
        ex      = w[30:23];
        mant    = {1'b1, w[22:0]};
        sh      = 5'(EXP_UNITY - ex);
        shifted = mant >> sh;
        if (ex == 8'd0) begin
            mag = '0;
        end else if (ex >= EXP_UNITY) begin
            mag = AXIS_MAX;
        end else if (ex <= EXP_ZERO_LO) begin
            mag = '0;
        end else if (shifted > 24'(AXIS_MAX)) begin
            mag = AXIS_MAX;
        end else begin
            mag = shifted[14:0];
        end
        return w[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    // Bias removal and dead zone; raw passes through until bias is captured.
    function automatic axis_out_t axis_correct(input axis_t raw, input axis_t bias,
                                               input logic bias_ok,
                                               input logic [DZ_W-1:0] dz);
        logic signed [OUT_W:0] rr;
        logic signed [OUT_W:0] dd;
        logic signed [OUT_W:0] lo;
        logic signed [OUT_W:0] hi;
        dd = $signed({3'b000, dz});
        rr = (OUT_W+1)'(raw) - (OUT_W+1)'(bias);
        lo = rr + dd;
        hi = rr - dd;
        if (!bias_ok) begin
            return OUT_W'(raw);
        end else if (lo < 0) begin
            return OUT_W'(lo);
        end else if (hi > 0) begin
            return OUT_W'(hi);
        end else begin
            return '0;
        end
    endfunction

endpackage

// ===== hdl/joystick_packet_unpacker_top.sv =====
// Joystick packet unpacker: byte-serial packet parse, float axis conversion,
// bias / dead zone correction. Depends on jpu_pkg.
//
//  channel | ports                                   | direction | transfer carries
//  --------+-----------------------------------------+-----------+--------------------------
//  input   | s_valid s_ready s_func s_data_byte ...  | in        | one byte or bias command
//  result  | m_valid m_ready m_status m_yaw ...      | out       | status, 4 axes, 5 buttons
//  config  | cfg_wr_en cfg_index cfg_wr_data         | in        | register write, no wait
//
// One transfer per cycle unless the result stalls. An accepted transfer is
// held in the input register, then one pass writes the result register.
// Synchronous active-low reset clears counters, axes, bias and buttons.
// A stalled result holds the pipe; s_ready drops only when both registers are full.
// Float axes are converted as their last byte arrives (bytes 6, 10, 14, 18)
// and committed on byte 24 if the packet checks out.
module joystick_packet_unpacker_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic signed [16:0] m_yaw,
    output logic signed [16:0] m_throttle,
    output logic signed [16:0] m_roll,
    output logic signed [16:0] m_pitch,
    output logic [7:0]  m_arm_button,
    output logic [7:0]  m_flip_button,
    output logic [7:0]  m_flight_mode,
    output logic [7:0]  m_altitude_mode,
    output logic [7:0]  m_proactive_flag,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wr_data
);

    // configuration registers
    logic                          check_en_reg;
    logic [jpu_pkg::ADDR_W-1:0]    my_addr_reg;
    logic [jpu_pkg::DZ_W-1:0]      dead_zone_reg;

    // input register
    logic       s1_valid_reg;
    logic [1:0] s1_func_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_first_reg;

    // packet state
    logic [4:0] cnt_reg, cnt_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] pkt_reg [jpu_pkg::STORE_DEPTH];
    jpu_pkg::axis_t pend_reg [jpu_pkg::NUM_AXES];

    // committed state
    jpu_pkg::axis_t raw_reg  [jpu_pkg::NUM_AXES];
    jpu_pkg::axis_t raw_next [jpu_pkg::NUM_AXES];
    jpu_pkg::axis_t bias_reg [jpu_pkg::NUM_AXES];
    jpu_pkg::axis_t bias_next[jpu_pkg::NUM_AXES];
    logic           bias_ok_reg, bias_ok_next;
    logic [7:0]     btn_reg  [jpu_pkg::NUM_BUTTONS];
    logic [7:0]     btn_next [jpu_pkg::NUM_BUTTONS];

    // result register
    logic                  m_valid_reg;
    logic [1:0]            m_status_reg;
    jpu_pkg::axis_out_t    m_axis_reg [jpu_pkg::NUM_AXES];
    logic [7:0]            m_btn_reg  [jpu_pkg::NUM_BUTTONS];

    // pass control
    logic       advance;
    logic       consume;
    logic [4:0] idx;
    logic       pkt_we;
    logic       pend_we;
    logic [1:0] pend_slot;
    logic [23:0] flt_lo;
    jpu_pkg::axis_t conv;
    logic       emit;
    logic [1:0] status;

    assign advance = !m_valid_reg || m_ready;
    assign consume = s1_valid_reg && advance;
    assign s_ready = !s1_valid_reg || advance;

    // byte position; first_byte or an overrun restarts at 0
    always_comb begin
        if (s1_first_reg || (cnt_reg >= 5'(jpu_pkg::PACKET_BYTES))) begin
            idx = '0;
        end else begin
            idx = cnt_reg;
        end
    end

    // low three bytes of the float that ends at this position
    always_comb begin
        pend_slot = 2'd0;
        flt_lo    = '0;
        pend_we   = 1'b0;
        case (idx)
            5'd6: begin
                pend_slot = 2'd0;
                flt_lo    = {pkt_reg[5], pkt_reg[4], pkt_reg[3]};
                pend_we   = 1'b1;
            end
            5'd10: begin
                pend_slot = 2'd1;
                flt_lo    = {pkt_reg[9], pkt_reg[8], pkt_reg[7]};
                pend_we   = 1'b1;
            end
            5'd14: begin
                pend_slot = 2'd2;
                flt_lo    = {pkt_reg[13], pkt_reg[12], pkt_reg[11]};
                pend_we   = 1'b1;
            end
            5'd18: begin
                pend_slot = 2'd3;
                flt_lo    = {pkt_reg[17], pkt_reg[16], pkt_reg[15]};
                pend_we   = 1'b1;
            end
            default: begin
                pend_we   = 1'b0;
            end
        endcase
    end

    // pitch is stored negated
    always_comb begin
        if (pend_slot == 2'd3) begin
            conv = -jpu_pkg::float_to_fixed({s1_byte_reg, flt_lo});
        end else begin
            conv = jpu_pkg::float_to_fixed({s1_byte_reg, flt_lo});
        end
    end

    // main decode
    always_comb begin
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        bias_ok_next = bias_ok_reg;
        raw_next     = raw_reg;
        bias_next    = bias_reg;
        btn_next     = btn_reg;
        pkt_we       = 1'b0;
        emit         = 1'b0;
        status       = jpu_pkg::ST_OK;
        if (consume) begin
            unique case (s1_func_reg)
                jpu_pkg::FUNC_CAPTURE: begin
                    bias_next    = raw_reg;
                    bias_ok_next = 1'b1;
                    emit         = 1'b1;
                end
                jpu_pkg::FUNC_CLEAR: begin
                    for (int k = 0; k < jpu_pkg::NUM_AXES; k++) begin
                        bias_next[k] = '0;
                    end
                    bias_ok_next = 1'b0;
                    emit         = 1'b1;
                end
                jpu_pkg::FUNC_BYTE: begin
                    if (idx < 5'(jpu_pkg::LAST_IDX)) begin
                        pkt_we   = 1'b1;
                        sum_next = (idx == 5'd0) ? s1_byte_reg : sum_reg + s1_byte_reg;
                        cnt_next = idx + 5'd1;
                    end else begin
                        // last byte: checksum first, then address
                        cnt_next = '0;
                        emit     = 1'b1;
                        if (check_en_reg) begin
                            if (s1_byte_reg != sum_reg) begin
                                status = jpu_pkg::ST_CSUM;
                            end else if ({pkt_reg[0], pkt_reg[1], pkt_reg[2]} != my_addr_reg) begin
                                status = jpu_pkg::ST_ADDR;
                            end
                        end
                        if (status == jpu_pkg::ST_OK) begin
                            raw_next = pend_reg;
                            for (int k = 0; k < jpu_pkg::NUM_BUTTONS; k++) begin
                                btn_next[k] = pkt_reg[jpu_pkg::FIRST_BUTTON + k];
                            end
                        end
                    end
                end
                default: begin
                    emit = 1'b0;   // unused code: dropped
                end
            endcase
        end
    end

    // control and committed state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_en_reg  <= 1'b1;
            my_addr_reg   <= '0;
            dead_zone_reg <= '0;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            bias_ok_reg   <= 1'b0;
            for (int k = 0; k < jpu_pkg::NUM_AXES; k++) begin
                raw_reg[k]  <= '0;
                bias_reg[k] <= '0;
            end
            for (int k = 0; k < jpu_pkg::NUM_BUTTONS; k++) begin
                btn_reg[k] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    jpu_pkg::CFG_CHECK_EN:  check_en_reg  <= cfg_wr_data[0];
                    jpu_pkg::CFG_MY_ADDR:   my_addr_reg   <= cfg_wr_data;
                    jpu_pkg::CFG_DEAD_ZONE: dead_zone_reg <= cfg_wr_data[jpu_pkg::DZ_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                s1_valid_reg <= 1'b1;
            end else if (consume) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= emit;
            end
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            bias_ok_reg <= bias_ok_next;
            raw_reg     <= raw_next;
            bias_reg    <= bias_next;
            btn_reg     <= btn_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_func_reg  <= s_func;
            s1_byte_reg  <= s_data_byte;
            s1_first_reg <= s_first_byte;
        end
        if (pkt_we) begin
            pkt_reg[idx] <= s1_byte_reg;
        end
        if (consume && pend_we && (s1_func_reg == jpu_pkg::FUNC_BYTE)) begin
            pend_reg[pend_slot] <= conv;
        end
        if (emit) begin
            m_status_reg <= status;
            for (int k = 0; k < jpu_pkg::NUM_AXES; k++) begin
                m_axis_reg[k] <= jpu_pkg::axis_correct(raw_next[k], bias_next[k],
                                                       bias_ok_next, dead_zone_reg);
            end
            m_btn_reg <= btn_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_yaw            = m_axis_reg[0];
    assign m_throttle       = m_axis_reg[1];
    assign m_roll           = m_axis_reg[2];
    assign m_pitch          = m_axis_reg[3];
    assign m_arm_button     = m_btn_reg[0];
    assign m_flip_button    = m_btn_reg[1];
    assign m_flight_mode    = m_btn_reg[2];
    assign m_altitude_mode  = m_btn_reg[3];
    assign m_proactive_flag = m_btn_reg[4];

endmodule

// ===== hdl/jpu_checker.sv =====
// Port-level checks for the joystick packet unpacker, bound to the top level.
// Depends on jpu_pkg.
module jpu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic signed [16:0] m_yaw,
    input logic        cfg_wr_en,
    input logic [1:0]  cfg_index,
    input logic [23:0] cfg_wr_data
);

    // shadow of the check enable register
    logic check_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_en_reg <= 1'b1;
        end else if (cfg_wr_en && (cfg_index == jpu_pkg::CFG_CHECK_EN)) begin
            check_en_reg <= cfg_wr_data[0];
        end
    end

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_yaw))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == jpu_pkg::ST_OK) || (m_status == jpu_pkg::ST_CSUM) ||
                    (m_status == jpu_pkg::ST_ADDR))
        else $error("undefined status code");

    a_no_check: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !check_en_reg |-> m_status == jpu_pkg::ST_OK)
        else $error("packet rejected with checking off");

endmodule

bind joystick_packet_unpacker_top jpu_checker u_jpu_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_yaw       (m_yaw),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
);
